@@ rtl/kmp_stream_pattern_matcher_core_assert.svh @@
// Assertion macros used by the pattern matcher top level.
`ifndef KMP_STREAM_PATTERN_MATCHER_CORE_ASSERT_SVH
`define KMP_STREAM_PATTERN_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KMP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kmp_pkg.sv @@
// Types and constants of the stream pattern matcher.
`default_nettype none

package kmp_pkg;

  localparam int DATA_W    = 8;
  localparam int LEN_W     = 4;
  localparam int PAT_W     = 64;
  localparam int MS_W      = 10;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

  // "OK"
  localparam logic [PAT_W-1:0] RESET_PATTERN = 64'h0000_0000_0000_4B4F;
  localparam logic [LEN_W-1:0] RESET_LENGTH  = 4'd2;

  typedef struct packed {
    logic step;   // advance the match bit on this byte
    logic clear;  // drop all partial matches
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/kmp_cell.sv @@
// One matcher cell: compares one pattern position and holds its prefix match bit.
`default_nettype none

module kmp_cell (
  input  wire                            clk,
  input  wire                            rst,
  input  kmp_pkg::cell_ctrl_t            ctrl,
  input  wire  [kmp_pkg::DATA_W-1:0]     data_byte,
  input  wire  [kmp_pkg::DATA_W-1:0]     pat_byte,
  input  wire                            prev_match,
  output logic                           match_next,
  output logic                           match
);

  // prefix ending at this position matches if the shorter prefix matched
  // up to the previous byte and this byte equals our pattern byte
  assign match_next = prev_match && (data_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.step) begin
      match <= match_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/kmp_stream_pattern_matcher_core.sv @@
// Top level of the streaming byte pattern matcher.
// Usage:
//   cfg channel: cfg_index 0 writes the pattern bytes (byte 0 in bits 7..0),
//   index 1 writes the pattern length (0 acts as 1, above MAX_PATTERN as
//   MAX_PATTERN). Other indexes are ignored. Write only while idle; each
//   write drops partial matches but keeps the buffer result.
//   s_* channel: one buffer byte per transfer, s_tlast on the last byte.
//   m_* channel: one result per input byte: found flag, first match start
//   offset, offset overflow flag.
// Throughput: each result is registered as its byte is accepted; a new byte
//   is taken every cycle unless a result is stalled. The rate is set by the row
//   of MAX_PATTERN cells, which all compare the byte in parallel and pass
//   their prefix match bits to the next cell each byte.
// Stall: while m_tvalid is high and m_tready low, s_tready is low and the
//   result holds.
// Reset: pattern "OK", length 2, no match progress, offset zero, no result
//   pending. No clearing pass is needed.
`default_nettype none
`include "kmp_stream_pattern_matcher_core_assert.svh"

module kmp_stream_pattern_matcher_core #(
  parameter int MAX_PATTERN  = 8,
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire                                clk,
  input  wire                                rst,
  // config write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [kmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [kmp_pkg::PAT_W-1:0]          cfg_data,
  // input stream
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [kmp_pkg::DATA_W-1:0]         s_tdata,   // [7:0] data_byte
  input  wire                                s_tlast,   // end_of_buffer
  // result stream
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [kmp_pkg::OUT_W-1:0]          m_tdata    // [0] found, [10:1] match_start,
                                                        // [11] overflow, [15:12] zero
);

  localparam int OFF_W = $clog2(BUFFER_DEPTH + 1);
  localparam int SW    = (OFF_W > kmp_pkg::MS_W) ? OFF_W : kmp_pkg::MS_W;

  // configuration registers
  logic [kmp_pkg::PAT_W-1:0] pattern_bytes;
  logic [kmp_pkg::LEN_W-1:0] pattern_length;

  // buffer state
  logic [OFF_W-1:0]          byte_offset;
  logic                      found_flag;
  logic [kmp_pkg::MS_W-1:0]  first_match_start;
  logic                      offset_saturated;

  // result register
  logic                      out_found;
  logic [kmp_pkg::MS_W-1:0]  out_start;
  logic                      out_overflow;

  logic                      cfg_xfer;
  logic                      cfg_hit;
  logic                      in_xfer;
  logic                      saturated;
  logic                      search;
  logic                      hit;
  logic [kmp_pkg::LEN_W-1:0] n_eff;
  logic [SW-1:0]             start_full;
  logic [kmp_pkg::MS_W-1:0]  start_now;
  logic                      found_now;
  logic                      overflow_now;
  kmp_pkg::cell_ctrl_t       cell_ctrl;
  logic [MAX_PATTERN-1:0]    match_bits;
  logic [MAX_PATTERN-1:0]    match_next;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_xfer && ((cfg_index == kmp_pkg::REG_PATTERN_BYTES) ||
                                  (cfg_index == kmp_pkg::REG_PATTERN_LENGTH));

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  always_comb begin
    priority if (pattern_length == '0) begin
      n_eff = kmp_pkg::LEN_W'(1);
    end else if (pattern_length > kmp_pkg::LEN_W'(MAX_PATTERN)) begin
      n_eff = kmp_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      n_eff = pattern_length;
    end
  end

  // bytes at or beyond the buffer depth are not searched
  assign saturated = (byte_offset >= OFF_W'(BUFFER_DEPTH));
  assign search    = in_xfer && !saturated && !found_flag;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (n_eff == kmp_pkg::LEN_W'(i + 1)) begin
        hit = search && match_next[i];
      end
    end
  end

  assign start_full   = SW'(byte_offset) + SW'(1) - SW'(n_eff);
  assign start_now    = hit ? start_full[kmp_pkg::MS_W-1:0] : first_match_start;
  assign found_now    = found_flag || hit;
  assign overflow_now = offset_saturated || saturated;

  // a config write or a buffer's last byte wins over a step; a completed match also restarts progress
  assign cell_ctrl.clear = cfg_hit || (in_xfer && s_tlast) || hit;
  assign cell_ctrl.step  = search;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic prev;
    if (g == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_bits[g-1];
    end
    kmp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .data_byte  (s_tdata),
      .pat_byte   (pattern_bytes[kmp_pkg::DATA_W*g +: kmp_pkg::DATA_W]),
      .prev_match (prev),
      .match_next (match_next[g]),
      .match      (match_bits[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= kmp_pkg::RESET_PATTERN;
      pattern_length <= kmp_pkg::RESET_LENGTH;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        kmp_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        kmp_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[kmp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      found_flag        <= 1'b0;
      first_match_start <= '0;
      offset_saturated  <= 1'b0;
    end else if (in_xfer) begin
      if (s_tlast) begin
        byte_offset       <= '0;
        found_flag        <= 1'b0;
        first_match_start <= '0;
        offset_saturated  <= 1'b0;
      end else if (saturated) begin
        offset_saturated <= 1'b1;
      end else begin
        byte_offset <= byte_offset + OFF_W'(1);
        if (hit) begin
          found_flag        <= 1'b1;
          first_match_start <= start_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_found    <= found_now;
      out_start    <= found_now ? start_now : '0;
      out_overflow <= overflow_now;
    end
  end

  assign m_tdata = {4'b0000, out_overflow, out_start, out_found};

  `KMP_ASSERT_NEXT(a_restart_on_last, clk, rst, in_xfer && s_tlast,
    (byte_offset == '0) && !found_flag && !offset_saturated, "buffer state not restarted")
  `KMP_ASSERT_IMPL(a_offset_bound, clk, rst, 1'b1,
    byte_offset <= OFF_W'(BUFFER_DEPTH), "byte offset past buffer depth")
  `KMP_ASSERT_IMPL(a_no_progress_after_found, clk, rst, found_flag,
    match_bits == '0, "partial match kept after pattern found")
  `KMP_ASSERT_IMPL(a_start_zero_unfound, clk, rst, m_tvalid && !m_tdata[0],
    m_tdata[10:1] == '0, "match start set without a match")

endmodule

`default_nettype wire

@@ test/kmp_stream_pattern_matcher_core_tb.sv @@
// Self-checking testbench for the streaming byte pattern matcher, with a KMP model.
`timescale 1ns / 100ps

module kmp_stream_pattern_matcher_core_tb;

  localparam int MAX_PAT   = 8;
  localparam int BUF_DEPTH = 1024;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 200;
  localparam int NPHASE    = 18;
  localparam int PHASE_ITEMS = 28;

  // indexes past the register list; the block must ignore them
  localparam logic [kmp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [kmp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [3:0] LINK_NONE = 4'hF;

  // same bit order as m_tdata
  typedef struct packed {
    logic [3:0] pad;
    logic       overflow;
    logic [9:0] start;
    logic       found;
  } match_result_t;

  class kmp_result_tracker;
    logic [63:0]   pattern;
    logic [3:0]    plen;
    logic [3:0]    fail_link [MAX_PAT];
    int            progress;
    int            offset;
    int            first_start;
    bit            found;
    bit            saturated;
    int            errors;
    match_result_t expected_results [$];

    function new();
      pattern = kmp_pkg::RESET_PATTERN;
      plen    = kmp_pkg::RESET_LENGTH;
      errors  = 0;
      restart();
      rebuild();
    endfunction

    function void restart();
      progress    = 0;
      offset      = 0;
      found       = 0;
      first_start = 0;
      saturated   = 0;
    endfunction

    function int eff_len();
      int n;
      n = plen;
      if (n < 1) n = 1;
      if (n > MAX_PAT) n = MAX_PAT;
      return n;
    endfunction

    function logic [7:0] pat_byte(int i);
      return pattern[8 * (i & 7) +: 8];
    endfunction

    function int link_at(int i);
      logic [3:0] v;
      v = fail_link[i & 7];
      return (v == LINK_NONE) ? -1 : int'(v);
    endfunction

    // optimized KMP failure links
    function void rebuild();
      int n, j, k, guard;
      n = eff_len();
      j = 0;
      k = -1;
      guard = 0;
      foreach (fail_link[i]) fail_link[i] = 4'd0;
      fail_link[0] = LINK_NONE;
      while (j < n - 1 && guard < 256) begin
        guard++;
        if (k == -1 || pat_byte(j) == pat_byte(k)) begin
          j++;
          k++;
          if (pat_byte(j) != pat_byte(k)) fail_link[j] = 4'(k);
          else fail_link[j] = fail_link[k];
        end else begin
          k = link_at(k);
        end
      end
    endfunction

    function void reg_write(logic [kmp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      if (idx == kmp_pkg::REG_PATTERN_BYTES) pattern = val;
      else if (idx == kmp_pkg::REG_PATTERN_LENGTH) plen = val[3:0];
      else return;
      rebuild();
      progress = 0;
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      int n, j, guard;
      match_result_t r;
      if (offset >= BUF_DEPTH) begin
        saturated = 1;
      end else begin
        if (!found) begin
          n = eff_len();
          j = progress;
          guard = 0;
          if (j >= n) j = 0;
          while (j != -1 && c != pat_byte(j) && guard <= MAX_PAT) begin
            j = link_at(j);
            guard++;
          end
          if (j != -1 && c != pat_byte(j)) j = -1;
          j++;
          if (j >= n) begin
            found       = 1;
            first_start = offset + 1 - n;
            progress    = 0;
          end else begin
            progress = j;
          end
        end
        offset++;
      end
      r.pad      = 4'd0;
      r.found    = found;
      r.start    = found ? 10'(first_start) : 10'd0;
      r.overflow = saturated;
      expected_results.push_back(r);
      if (last) restart();
    endfunction

    function void report(string field, logic [9:0] want, logic [9:0] got);
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(match_result_t got);
      match_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found) report("found", want.found, got.found);
      if (got.start !== want.start) report("match_start", want.start, got.start);
      if (got.overflow !== want.overflow) report("overflow", want.overflow, got.overflow);
      if (got.pad !== want.pad) report("padding", want.pad, got.pad);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [kmp_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [kmp_pkg::PAT_W-1:0]         cfg_data;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [kmp_pkg::DATA_W-1:0]        s_tdata;
  logic                              s_tlast;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [kmp_pkg::OUT_W-1:0]         m_tdata;

  kmp_result_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int cycles;

  kmp_stream_pattern_matcher_core #(
    .MAX_PATTERN (MAX_PAT),
    .BUFFER_DEPTH(BUF_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_result(match_result_t'(m_tdata));
      if (s_tvalid && s_tready) tracker.note_byte(s_tdata, s_tlast);
      if (cfg_valid && cfg_ready) tracker.reg_write(cfg_index, cfg_data);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kmp_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text(input string txt, input logic last);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], last && (i == txt.len() - 1));
  endtask

  initial begin
    logic [63:0] pat;
    logic [3:0]  plen;
    logic [7:0]  sym [3];
    logic [7:0]  b;
    logic [7:0]  buffer [$];
    int nsym, n, blen, sent, k, r;

    tracker = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req  = 0;
    hold_ack  = 0;
    hold_left = 0;
    cycles    = 0;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= kmp_pkg::REG_PATTERN_BYTES;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pattern, extreme bytes, first match kept after a second one
    send_byte(8'h00, 1'b0);
    send_text("OKOK", 1'b0);
    send_byte(8'hFF, 1'b1);
    // spare index leaves progress alone
    send_text("O", 1'b0);
    write_reg(REG_SPARE_2, {$urandom, $urandom});
    send_text("K", 1'b1);
    // a real write drops the partial match but keeps the offset
    send_text("O", 1'b0);
    write_reg(kmp_pkg::REG_PATTERN_LENGTH, 64'd2);
    send_text("KOK", 1'b1);
    // zero byte pattern, length zero acts as one
    write_reg(REG_SPARE_3, {$urandom, $urandom});
    write_reg(kmp_pkg::REG_PATTERN_BYTES, 64'd0);
    write_reg(kmp_pkg::REG_PATTERN_LENGTH, 64'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
    // length above the maximum clamps; long self-overlapping pattern
    write_reg(kmp_pkg::REG_PATTERN_BYTES, 64'h4241_4141_4141_4141);
    write_reg(kmp_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    send_text("AAAAAAAAB", 1'b1);

    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph < NPHASE / 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 59;
      end else if (ph < 2 * NPHASE / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      nsym = $urandom_range(1, 3);
      foreach (sym[i]) sym[i] = 8'($urandom);
      if ($urandom_range(3) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int i = 0; i < 8; i++) pat[8 * i +: 8] = sym[$urandom_range(nsym - 1)];
      end
      case (ph)
        0: plen = 4'd1;
        1: plen = 4'd8;
        2: plen = 4'd0;
        3: plen = 4'd15;
        default: plen = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(1, 8));
      endcase
      if (ph % 4 == 3) begin
        write_reg(kmp_pkg::REG_PATTERN_BYTES, pat);
      end else if ($urandom_range(1)) begin
        write_reg(kmp_pkg::REG_PATTERN_BYTES, pat);
        write_reg(kmp_pkg::REG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
      end else begin
        write_reg(kmp_pkg::REG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
        write_reg(kmp_pkg::REG_PATTERN_BYTES, pat);
      end
      // let the tracker take the last write before reading it back
      @(posedge clk);
      pat  = tracker.pattern;
      n    = tracker.eff_len();

      if (ph == 4 || ph == 13) hold_req++;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        blen = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
        buffer.delete();
        while (buffer.size() < blen) begin
          r = $urandom_range(9);
          if (r < 4) begin
            // whole pattern or a prefix of it, to walk the failure links
            k = ($urandom_range(2) == 0) ? $urandom_range(1, n) : n;
            for (int i = 0; i < k; i++) buffer.push_back(pat[8 * i +: 8]);
          end else if (r < 8) begin
            buffer.push_back(sym[$urandom_range(nsym - 1)]);
          end else begin
            buffer.push_back(8'($urandom));
          end
        end
        foreach (buffer[i]) send_byte(buffer[i], i == buffer.size() - 1);
        sent += buffer.size();
      end

      // one buffer longer than the depth, single byte match at the last slot
      if (ph == NPHASE - 1) begin
        b = 8'($urandom);
        write_reg(kmp_pkg::REG_PATTERN_BYTES, {$urandom, 24'($urandom), b});
        write_reg(kmp_pkg::REG_PATTERN_LENGTH, 64'd1);
        for (int i = 0; i < BUF_DEPTH - 1; i++) send_byte(b ^ 8'($urandom_range(1, 255)), 1'b0);
        send_byte(b, 1'b0);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom), i == 5);
        send_byte(b, 1'b1);
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ kmp_stream_pattern_matcher_core.f @@
+incdir+rtl
rtl/kmp_pkg.sv
rtl/kmp_cell.sv
rtl/kmp_stream_pattern_matcher_core.sv
test/kmp_stream_pattern_matcher_core_tb.sv
